// File: hw/rtl/cbtp_pkg.sv
// Shared constants for the counter-based task picker.
package cbtp_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int TASK_SLOTS_DEF   = 16;
    localparam int COUNTER_BITS_DEF = 8;

    // Number of slots that the signal mask covers.
    localparam int SIG_BITS = 16;

    // Run states of a task slot.
    localparam logic [1:0] ST_RUNNING         = 2'd0;
    localparam logic [1:0] ST_INTERRUPTIBLE   = 2'd1;
    localparam logic [1:0] ST_UNINTERRUPTIBLE = 2'd2;
    localparam logic [1:0] ST_UNKNOWN         = 2'd3;

    // Item kinds carried in tuser; the last code takes no action but still yields a result.
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_WAKE  = 2'd1;
    localparam logic [1:0] KIND_SCHED = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Configuration register indexes and reset values.
    localparam int         CFG_IDX_W       = 1;
    localparam int         CFG_DATA_W      = 8;
    localparam logic [0:0] CFG_DEFAULT_CNT = 1'b0;
    localparam logic [0:0] CFG_MAX_CNT     = 1'b1;
    localparam logic [7:0] DEF_CNT_RESET   = 8'd15;
    localparam logic [7:0] MAX_CNT_RESET   = 8'd30;

endpackage

// File: hw/rtl/cbtp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module cbtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/counter_based_task_picker_top.sv
// Top level of the counter-based task picker: slot table, run queue and sequencer.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------------
//  s_*      | in        | s_tvalid/s_tready | tuser kind, tdata slot/counter/state/mask
//  m_*      | out       | m_tvalid/m_tready | tdata next_task/switched/recalc/idle
//  i_cfg_*  | in        | i_cfg_wr_en       | i_cfg_idx, i_cfg_data
//
// After acceptance a load reads and then writes its slot entry; a wake reads the slot and,
// unless the task is already queued, marks it running and pushes it to the queue front.
// A schedule updates the current task, unlinks it from the queue when it stops running,
// sweeps the signal slots and pushes each woken task, picks from the queue, recalculates
// every counter when the best one is zero, then hands over the result; RAM walks take one entry per cycle.
// After reset a clearing pass writes every slot RAM entry; no item is taken during it.
// A finished result waits in the output register while the next item is accepted.
module counter_based_task_picker_top
    import cbtp_pkg::*;
#(
    parameter int TASK_SLOTS   = TASK_SLOTS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // task_slot[3:0], counter_value[11:4], new_state[13:12], signal_mask[29:14]
    input  logic [31:0]           s_tdata,
    // kind[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // next_task[3:0], switched[4], recalculated[5], idle_fallback[6]
    output logic [7:0]            m_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int LEN_W  = $clog2(TASK_SLOTS + 1);
    localparam int ENT_W  = COUNTER_BITS + 3;
    localparam int WAKE_N = (TASK_SLOTS < SIG_BITS) ? TASK_SLOTS : SIG_BITS;
    localparam int SUM_W  = ((COUNTER_BITS > CFG_DATA_W) ? COUNTER_BITS : CFG_DATA_W) + 1;
    localparam logic [COUNTER_BITS-1:0] CMAX = '1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LD_RD, S_LD_WR, S_WK_RD, S_WK_WR, S_PUSH, S_SC_RD,
        S_SC_WR, S_REM, S_SIG_RD, S_SIG_CHK, S_PICK, S_RECALC, S_DONE
    } t_state;

    t_state                  r_state, r_ret;
    logic [LEN_W-1:0]        r_idx, r_widx, r_pa, r_len;
    logic [SLOT_W-1:0]       r_cur, r_slot, r_ps, r_bslot, r_next;
    logic [1:0]              r_nst;
    logic [SIG_BITS-1:0]     r_sig;
    logic [CFG_DATA_W-1:0]   r_cval, r_def, r_max;
    logic [COUNTER_BITS-1:0] r_best;
    logic                    r_pv, r_v2, r_found, r_have, r_recalc, r_idle;
    logic                    r_ov;
    logic [7:0]              r_odata;

    // RAM ports.
    logic                    s_we, q_we;
    logic [SLOT_W-1:0]       s_waddr, s_raddr, q_waddr, q_raddr;
    logic [ENT_W-1:0]        s_wdata, s_rd;
    logic [SLOT_W-1:0]       q_wdata, q_rd;

    // Slot table entry: state, queued flag and counter.
    cbtp_ram #(.WIDTH(ENT_W), .DEPTH(TASK_SLOTS)) u_slot_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rd)
    );

    // Run queue order, front at entry 0.
    cbtp_ram #(.WIDTH(SLOT_W), .DEPTH(TASK_SLOTS)) u_queue_ram (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rd)
    );

    // Fields of the entry just read.
    logic [COUNTER_BITS-1:0] w_cnt;
    logic                    w_queued;
    logic [1:0]              w_st;
    assign w_cnt    = s_rd[COUNTER_BITS-1:0];
    assign w_queued = s_rd[COUNTER_BITS];
    assign w_st     = s_rd[COUNTER_BITS+2:COUNTER_BITS+1];

    // Input slot, sized to the table, and its range check.
    logic [SLOT_W+3:0] w_slot_ext;
    logic              w_in_range;
    assign w_slot_ext = {{SLOT_W{1'b0}}, s_tdata[3:0]};
    assign w_in_range = ({{LEN_W{1'b0}}, s_tdata[3:0]} < (LEN_W + 4)'(TASK_SLOTS));

    // Next task widened so that the result field is always four bits.
    logic [SLOT_W+3:0] w_next_ext;
    assign w_next_ext = {4'b0, r_next};

    // Saturated load value.
    logic [SUM_W-1:0]        w_ld_ext;
    logic [COUNTER_BITS-1:0] w_ld_sat;
    assign w_ld_ext = SUM_W'(r_cval);
    always_comb begin
        if (w_ld_ext > SUM_W'(CMAX)) begin
            w_ld_sat = CMAX;
        end else begin
            w_ld_sat = w_ld_ext[COUNTER_BITS-1:0];
        end
    end

    // Recalculated counter: half plus default, capped twice.
    logic [SUM_W-1:0]        w_rc_sum, w_rc_cap;
    logic [COUNTER_BITS-1:0] w_rc_sat;
    assign w_rc_sum = SUM_W'(w_cnt >> 1) + SUM_W'(r_def);
    always_comb begin
        if (w_rc_sum > SUM_W'(r_max)) begin
            w_rc_cap = SUM_W'(r_max);
        end else begin
            w_rc_cap = w_rc_sum;
        end
        if (w_rc_cap > SUM_W'(CMAX)) begin
            w_rc_sat = CMAX;
        end else begin
            w_rc_sat = w_rc_cap[COUNTER_BITS-1:0];
        end
    end

    // Signal wakeup test for the slot in the wake sweep.
    logic [SIG_BITS-1:0] w_sig_sh;
    logic                w_wake;
    assign w_sig_sh = r_sig >> r_widx;
    assign w_wake   = (w_st == ST_INTERRUPTIBLE) && w_sig_sh[0] && !w_queued;

    logic [LEN_W-1:0] w_idx_m1, w_pa_m1;
    assign w_idx_m1 = r_idx - 1'b1;
    assign w_pa_m1  = r_pa - 1'b1;

    // RAM port control per sequencer state.
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_slot;
        s_wdata = s_rd;
        s_raddr = r_slot;
        q_we    = 1'b0;
        q_waddr = r_pa[SLOT_W-1:0];
        q_wdata = q_rd;
        q_raddr = r_idx[SLOT_W-1:0];
        case (r_state)
            S_CLEAR: begin
                s_we    = 1'b1;
                s_waddr = r_idx[SLOT_W-1:0];
                s_wdata = {((r_idx == '0) ? ST_RUNNING : ST_UNINTERRUPTIBLE), 1'b0,
                           {COUNTER_BITS{1'b0}}};
            end
            S_LD_WR: begin
                s_we    = 1'b1;
                s_wdata = {w_st, w_queued, w_ld_sat};
            end
            S_WK_WR: begin
                s_we    = !w_queued;
                s_wdata = {ST_RUNNING, 1'b1, w_cnt};
            end
            S_PUSH: begin
                q_raddr = w_idx_m1[SLOT_W-1:0];
                q_we    = r_pv;
                if (r_idx == '0 && !r_pv) begin
                    q_we    = 1'b1;
                    q_waddr = '0;
                    q_wdata = r_slot;
                end
            end
            S_SC_RD: begin
                s_raddr = r_cur;
            end
            S_SC_WR: begin
                s_we    = 1'b1;
                s_waddr = r_cur;
                s_wdata = {r_nst, (r_nst == ST_RUNNING) && w_queued, w_cnt};
            end
            S_REM: begin
                q_we    = r_pv && r_found;
                q_waddr = w_pa_m1[SLOT_W-1:0];
            end
            S_SIG_RD: begin
                s_raddr = r_widx[SLOT_W-1:0];
            end
            S_SIG_CHK: begin
                s_we    = w_wake;
                s_waddr = r_widx[SLOT_W-1:0];
                s_wdata = {ST_RUNNING, 1'b1, w_cnt};
            end
            S_PICK: begin
                s_raddr = q_rd;
            end
            S_RECALC: begin
                s_raddr = r_idx[SLOT_W-1:0];
                s_we    = r_pv;
                s_waddr = r_pa[SLOT_W-1:0];
                s_wdata = {w_st, w_queued, w_rc_sat};
            end
            default: begin
            end
        endcase
    end

    // Sequencer, queue bookkeeping and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ret   <= S_DONE;
            r_idx   <= '0;
            r_len   <= '0;
            r_cur   <= '0;
            r_pv    <= 1'b0;
            r_v2    <= 1'b0;
            r_ov    <= 1'b0;
            r_def   <= DEF_CNT_RESET;
            r_max   <= MAX_CNT_RESET;
        end else begin
            // Configuration writes.
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == CFG_DEFAULT_CNT) begin
                    r_def <= i_cfg_data;
                end else begin
                    r_max <= i_cfg_data;
                end
            end

            // The output register empties when taken, unless it is refilled below.
            if (r_ov && m_tready && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LEN_W'(TASK_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_slot   <= w_slot_ext[SLOT_W-1:0];
                        r_cval   <= s_tdata[11:4];
                        r_nst    <= (s_tdata[13:12] == ST_UNKNOWN) ? ST_UNINTERRUPTIBLE
                                                                    : s_tdata[13:12];
                        r_sig    <= s_tdata[29:14];
                        r_next   <= r_cur;
                        r_recalc <= 1'b0;
                        r_idle   <= 1'b0;
                        r_ret    <= S_DONE;
                        case (s_tuser)
                            KIND_LOAD:  r_state <= w_in_range ? S_LD_RD : S_DONE;
                            KIND_WAKE:  r_state <= w_in_range ? S_WK_RD : S_DONE;
                            KIND_SCHED: r_state <= S_SC_RD;
                            default:    r_state <= S_DONE;
                        endcase
                    end
                end
                S_LD_RD: r_state <= S_LD_WR;
                S_LD_WR: r_state <= S_DONE;
                S_WK_RD: r_state <= S_WK_WR;
                S_WK_WR: begin
                    r_idx <= r_len;
                    r_pv  <= 1'b0;
                    r_state <= w_queued ? S_DONE : S_PUSH;
                end
                // Shift the queue back by one, last entry first, then fill the front.
                S_PUSH: begin
                    if (r_idx != '0) begin
                        r_pa  <= r_idx;
                        r_idx <= w_idx_m1;
                        r_pv  <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_len   <= r_len + 1'b1;
                            r_state <= r_ret;
                        end
                    end
                end
                S_SC_RD: r_state <= S_SC_WR;
                S_SC_WR: begin
                    r_idx   <= '0;
                    r_widx  <= '0;
                    r_pv    <= 1'b0;
                    r_found <= 1'b0;
                    r_ret   <= S_SIG_RD;
                    if (r_nst != ST_RUNNING && w_queued) begin
                        r_state <= S_REM;
                    end else begin
                        r_state <= S_SIG_RD;
                    end
                end
                // Unlink the current task; entries behind it move forward by one.
                S_REM: begin
                    if (r_idx < r_len) begin
                        r_pa  <= r_idx;
                        r_idx <= r_idx + 1'b1;
                        r_pv  <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && !r_found && q_rd == r_cur) begin
                        r_found <= 1'b1;
                    end
                    if (!(r_idx < r_len) && !r_pv) begin
                        r_len   <= r_len - 1'b1;
                        r_state <= S_SIG_RD;
                    end
                end
                // Signal wakeups in slot order.
                S_SIG_RD: begin
                    if (r_widx == LEN_W'(WAKE_N)) begin
                        r_idx   <= '0;
                        r_pv    <= 1'b0;
                        r_v2    <= 1'b0;
                        r_have  <= 1'b0;
                        r_state <= S_PICK;
                    end else begin
                        r_state <= S_SIG_CHK;
                    end
                end
                S_SIG_CHK: begin
                    r_widx <= r_widx + 1'b1;
                    if (w_wake) begin
                        r_slot  <= r_widx[SLOT_W-1:0];
                        r_idx   <= r_len;
                        r_pv    <= 1'b0;
                        r_state <= S_PUSH;
                    end else begin
                        r_state <= S_SIG_RD;
                    end
                end
                // Queue walk: order read, slot read, counter compare.
                S_PICK: begin
                    if (r_idx < r_len) begin
                        r_idx <= r_idx + 1'b1;
                        r_pv  <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    r_v2 <= r_pv;
                    r_ps <= q_rd;
                    if (r_v2 && (!r_have || w_cnt > r_best)) begin
                        r_have  <= 1'b1;
                        r_best  <= w_cnt;
                        r_bslot <= r_ps;
                    end
                    if (!(r_idx < r_len) && !r_pv && !r_v2) begin
                        r_next   <= r_have ? r_bslot : '0;
                        r_idle   <= (r_len == '0);
                        r_recalc <= r_have && (r_best == '0);
                        r_idx    <= '0;
                        r_state  <= (r_have && r_best == '0) ? S_RECALC : S_DONE;
                    end
                end
                // Recompute every counter, reading one slot while writing the previous.
                S_RECALC: begin
                    if (r_idx != LEN_W'(TASK_SLOTS)) begin
                        r_pa  <= r_idx;
                        r_idx <= r_idx + 1'b1;
                        r_pv  <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                // Hand the result to the output register once it is free.
                S_DONE: begin
                    if (!r_ov || m_tready) begin
                        r_ov    <= 1'b1;
                        r_odata <= {1'b0, r_idle, r_recalc, (r_next != r_cur),
                                    w_next_ext[3:0]};
                        r_cur   <= r_next;
                        r_state <= S_IDLE;
                    end else if (r_ov && m_tready) begin
                        r_ov <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_ov;
    assign m_tdata  = r_odata;

endmodule

// File: hw/rtl/cbtp_checker.sv
// Port-level checks for the counter-based task picker, bound to the top level.
module cbtp_props
    import cbtp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [7:0]            m_tdata
);

    // A result that is not taken holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result present after reset");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // An idle fallback never recalculates and always names the idle slot.
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[6] |-> !m_tdata[5] && (m_tdata[3:0] == 4'd0))
        else $error("bad idle fallback result");

endmodule

bind counter_based_task_picker_top cbtp_props u_cbtp_props (.*);

// File: dv/cbtp_checker.sv
// Checker for the task picker: watches both streams, predicts each result and compares it.
`timescale 1ns / 1ps

module cbtp_checker
    import cbtp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [31:0]           s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int NS = 16;

    // Shadow of the slot table and run queue.
    logic [1:0] run_state [NS];
    logic [7:0] slot_cnt  [NS];
    logic       on_queue  [NS];
    logic [3:0] rq        [NS];
    int         rq_len;
    logic [3:0] cur_task;
    logic [7:0] def_cnt;
    logic [7:0] max_cnt;

    logic [6:0] pick_q [$];

    function automatic void rq_push_front(input logic [3:0] s);
        if (rq_len < NS) begin
            for (int i = rq_len; i > 0; i--) rq[i] = rq[i-1];
            rq[0] = s;
            rq_len++;
            on_queue[s] = 1'b1;
        end
    endfunction

    function automatic void rq_remove(input logic [3:0] s);
        if (on_queue[s]) begin
            for (int i = 0; i < rq_len; i++) begin
                if (rq[i] == s) begin
                    for (int j = i; j + 1 < rq_len; j++) rq[j] = rq[j+1];
                    rq_len--;
                    break;
                end
            end
            on_queue[s] = 1'b0;
        end
    endfunction

    function automatic void wake(input logic [3:0] s);
        if (!on_queue[s]) begin
            run_state[s] = ST_RUNNING;
            rq_push_front(s);
        end
    endfunction

    // Applies one item to the shadow state and returns the expected result.
    function automatic logic [6:0] pick_next(input logic [1:0] kind, input logic [31:0] d);
        logic [3:0]  slot;
        logic [1:0]  nst;
        logic [15:0] sig;
        logic [3:0]  prev;
        logic [3:0]  nxt;
        int          best;
        int          v;
        logic        recalc;
        logic        idle;
        slot   = d[3:0];
        nst    = d[13:12];
        sig    = d[29:14];
        prev   = cur_task;
        nxt    = cur_task;
        recalc = 1'b0;
        idle   = 1'b0;
        if (kind == KIND_LOAD) begin
            slot_cnt[slot] = d[11:4];
        end else if (kind == KIND_WAKE) begin
            wake(slot);
        end else if (kind == KIND_SCHED) begin
            if (nst == ST_UNKNOWN) nst = ST_UNINTERRUPTIBLE;
            run_state[prev] = nst;
            if (nst != ST_RUNNING) rq_remove(prev);
            for (int i = 0; i < NS; i++)
                if (run_state[i] == ST_INTERRUPTIBLE && sig[i]) wake(i[3:0]);
            best = -100;
            nxt  = '0;
            for (int i = 0; i < rq_len; i++) begin
                if (int'(slot_cnt[rq[i]]) > best) begin
                    best = slot_cnt[rq[i]];
                    nxt  = rq[i];
                end
            end
            idle = (rq_len == 0);
            if (best == 0) begin
                recalc = 1'b1;
                for (int i = 0; i < NS; i++) begin
                    v = slot_cnt[i] / 2 + def_cnt;
                    if (v > max_cnt) v = max_cnt;
                    if (v > 255) v = 255;
                    slot_cnt[i] = v[7:0];
                end
            end
            cur_task = nxt;
        end
        return {idle, recalc, nxt != prev, nxt};
    endfunction

    // Predict on input items, compare on output items.
    always @(posedge i_clk) begin
        logic [6:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) begin
                run_state[i] = ST_UNINTERRUPTIBLE;
                slot_cnt[i]  = '0;
                on_queue[i]  = 1'b0;
                rq[i]        = '0;
            end
            run_state[0] = ST_RUNNING;
            rq_len   = 0;
            cur_task = '0;
            def_cnt  = DEF_CNT_RESET;
            max_cnt  = MAX_CNT_RESET;
            o_errors = 0;
            pick_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == CFG_DEFAULT_CNT) def_cnt = i_cfg_data;
                else max_cnt = i_cfg_data;
            end
            if (m_tvalid && m_tready) begin
                if (pick_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    want = pick_q.pop_front();
                    if (m_tdata[6:0] !== want) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("mismatch: expected next=%0d sw=%b rc=%b idle=%b",
                                want[3:0], want[4], want[5], want[6]);
                            $display("          got      next=%0d sw=%b rc=%b idle=%b",
                                m_tdata[3:0], m_tdata[4], m_tdata[5], m_tdata[6]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) pick_q.push_back(pick_next(s_tuser, s_tdata));
        end
        o_pending = pick_q.size();
    end

endmodule

// File: dv/tb.sv
// Testbench top: clock, reset, stimulus, configuration and the verdict.
`timescale 1ns / 1ps

module tb;
    import cbtp_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    errors;
    int                    pending;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    hold_off;
    int                    quiet_cycles;

    counter_based_task_picker_top i_dut (.*);

    cbtp_checker i_chk (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .i_cfg_wr_en, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    initial m_tready = 1'b0;
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one item after random gaps and holds it until ready is seen after an edge;
    // valid then stays up until the next item or a gap replaces it.
    task automatic send_item(input logic [1:0] kind, input logic [3:0] slot,
                             input logic [7:0] cnt, input logic [1:0] nst,
                             input logic [15:0] sig);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, sig, nst, cnt, slot};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly wakes and schedules over any of the sixteen slots so the queue gets busy.
    task automatic random_item();
        int r;
        logic [1:0] kind;
        r = $urandom_range(99);
        if (r < 25) kind = KIND_LOAD;
        else if (r < 50) kind = KIND_WAKE;
        else if (r < 97) kind = KIND_SCHED;
        else kind = KIND_NONE;
        send_item(kind, 4'($urandom_range(15)),
                  ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3)),
                  ($urandom_range(2) == 0) ? 2'($urandom_range(3)) : ST_RUNNING,
                  16'($urandom()));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        send_idle_pct = 9;
        recv_idle_pct = 54;
        hold_off      = 0;
        quiet_cycles  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, extremes, every kind and state, unknown codes.
        send_item(KIND_SCHED, 4'd0, 8'd0, ST_INTERRUPTIBLE, 16'hFFFF);
        send_item(KIND_SCHED, 4'd0, 8'd0, ST_RUNNING, 16'h0000);
        send_item(KIND_WAKE, 4'd15, 8'd0, ST_RUNNING, 16'h0);
        send_item(KIND_WAKE, 4'd15, 8'd0, ST_RUNNING, 16'h0);
        send_item(KIND_LOAD, 4'd15, 8'd255, ST_RUNNING, 16'h0);
        send_item(KIND_WAKE, 4'd3, 8'd0, ST_RUNNING, 16'h0);
        send_item(KIND_LOAD, 4'd3, 8'd255, ST_RUNNING, 16'h0);
        send_item(KIND_SCHED, 4'd0, 8'd0, ST_RUNNING, 16'h0);
        send_item(KIND_SCHED, 4'd0, 8'd0, ST_INTERRUPTIBLE, 16'h0);
        send_item(KIND_SCHED, 4'd0, 8'd0, ST_UNKNOWN, 16'hFFFF);
        send_item(KIND_NONE, 4'd7, 8'd99, ST_UNKNOWN, 16'hFFFF);
        send_item(KIND_LOAD, 4'd0, 8'd0, ST_RUNNING, 16'h0);
        send_item(KIND_SCHED, 4'd0, 8'd0, ST_INTERRUPTIBLE, 16'h8001);
        send_item(KIND_SCHED, 4'd0, 8'd0, ST_UNINTERRUPTIBLE, 16'hAAAA);
        send_item(KIND_SCHED, 4'd0, 8'd0, ST_INTERRUPTIBLE, 16'h5555);
        send_item(KIND_SCHED, 4'd0, 8'd0, ST_RUNNING, 16'hFFFF);

        // Random phases with register settings including the extremes.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_DEFAULT_CNT, 8'd0);   write_reg(CFG_MAX_CNT, 8'd0);   end
                1: begin write_reg(CFG_DEFAULT_CNT, 8'd255); write_reg(CFG_MAX_CNT, 8'd255); end
                2: begin write_reg(CFG_DEFAULT_CNT, 8'd200); write_reg(CFG_MAX_CNT, 8'd7);   end
                3: begin write_reg(CFG_DEFAULT_CNT, 8'($urandom_range(255)));
                         write_reg(CFG_MAX_CNT, 8'($urandom_range(255))); end
                4: begin write_reg(CFG_DEFAULT_CNT, 8'd1);   write_reg(CFG_MAX_CNT, 8'd3);   end
                default: begin write_reg(CFG_DEFAULT_CNT, 8'd15); write_reg(CFG_MAX_CNT, 8'd30); end
            endcase
            if (ph == 2) begin send_idle_pct = 54; recv_idle_pct = 9; end
            if (ph == 4) begin send_idle_pct = 0;  recv_idle_pct = 0; end
            if (ph == 5) hold_off = 600;
            for (int n = 0; n < 322; n++) random_item();
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/cbtp_pkg.sv
hw/rtl/cbtp_ram.sv
hw/rtl/counter_based_task_picker_top.sv
hw/rtl/cbtp_checker.sv
dv/cbtp_checker.sv
dv/tb.sv
